/* hdl/weighted_unit_priority_scheduler_assert.svh */
// Assertion macros shared by the scheduler modules.
`ifndef WEIGHTED_UNIT_PRIORITY_SCHEDULER_ASSERT_SVH
`define WEIGHTED_UNIT_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WUPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WUPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wups_pkg.sv */
// Shared constants, types and width helpers for the scheduler.
`timescale 1ns / 1ps
`default_nettype none
package wups_pkg;

    localparam int DEPTH       = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int UNITS_BITS  = 16;
    localparam int FIELD_BITS  = 16;
    localparam int SUM_BITS    = 48;
    localparam int CNT_OUT_BITS = 7;
    localparam int COUNT_BITS  = $clog2(DEPTH + 1);
    localparam int PROD_BITS   = WEIGHT_BITS + UNITS_BITS;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_POP    = 3'd2,
        CMD_DEC    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    // One slot of the sorted chain
    typedef struct packed {
        logic                   valid;
        logic [WEIGHT_BITS-1:0] weight;
        logic [UNITS_BITS-1:0]  units;
    } cell_t;

    // Command broadcast along the chain
    typedef struct packed {
        cmd_t                   cmd;
        logic [WEIGHT_BITS-1:0] weight;
        logic [UNITS_BITS-1:0]  units;
    } chain_cmd_t;

    function automatic logic [WEIGHT_BITS-1:0] fit_weight(input logic [FIELD_BITS-1:0] v);
        logic [WEIGHT_BITS+FIELD_BITS-1:0] wide;
        wide = {{WEIGHT_BITS{1'b0}}, v};
        return wide[WEIGHT_BITS-1:0];
    endfunction

    function automatic logic [UNITS_BITS-1:0] fit_units(input logic [FIELD_BITS-1:0] v);
        logic [UNITS_BITS+FIELD_BITS-1:0] wide;
        wide = {{UNITS_BITS{1'b0}}, v};
        return wide[UNITS_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] weight_field(input logic [WEIGHT_BITS-1:0] v);
        logic [WEIGHT_BITS+FIELD_BITS-1:0] wide;
        wide = {{FIELD_BITS{1'b0}}, v};
        return wide[FIELD_BITS-1:0];
    endfunction

    function automatic logic [SUM_BITS-1:0] fit_sum(input logic [PROD_BITS-1:0] v);
        logic [SUM_BITS+PROD_BITS-1:0] wide;
        wide = {{SUM_BITS{1'b0}}, v};
        return wide[SUM_BITS-1:0];
    endfunction

    function automatic logic [CNT_OUT_BITS-1:0] count_field(input logic [COUNT_BITS-1:0] v);
        logic [CNT_OUT_BITS+COUNT_BITS-1:0] wide;
        wide = {{CNT_OUT_BITS{1'b0}}, v};
        return wide[CNT_OUT_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/wups_cell.sv */
// One slot of the weight-sorted job chain.
`timescale 1ns / 1ps
`default_nettype none
module wups_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wups_pkg::chain_cmd_t cmd,
    input  wire logic                take_left,  // left neighbor takes the new job
    input  wire wups_pkg::cell_t     left,
    input  wire wups_pkg::cell_t     right,
    output logic                     take,
    output wups_pkg::cell_t          state
);

    logic                             valid_reg, valid_next;
    logic [wups_pkg::WEIGHT_BITS-1:0] weight_reg, weight_next;
    logic [wups_pkg::UNITS_BITS-1:0]  units_reg, units_next;

    // New job lands here or further left when it outranks this slot
    assign take = (cmd.cmd == wups_pkg::CMD_INSERT) && (!valid_reg || (cmd.weight > weight_reg));

    assign state.valid  = valid_reg;
    assign state.weight = weight_reg;
    assign state.units  = units_reg;

    // Next slot contents
    always_comb
    begin
        valid_next  = valid_reg;
        weight_next = weight_reg;
        units_next  = units_reg;
        case (cmd.cmd)
            wups_pkg::CMD_INSERT:
            begin
                if (take_left)
                begin
                    valid_next  = left.valid;
                    weight_next = left.weight;
                    units_next  = left.units;
                end
                else if (take)
                begin
                    valid_next  = 1'b1;
                    weight_next = cmd.weight;
                    units_next  = cmd.units;
                end
            end
            wups_pkg::CMD_POP:
            begin
                valid_next  = right.valid;
                weight_next = right.weight;
                units_next  = right.units;
            end
            wups_pkg::CMD_DEC:
            begin
                units_next = units_reg - 1'b1;
            end
            wups_pkg::CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        units_reg  <= units_next;
    end

endmodule
`default_nettype wire

/* hdl/wups_chain.sv */
// Row of sorted job cells, highest weight at the head.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_unit_priority_scheduler_assert.svh"
module wups_chain (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wups_pkg::chain_cmd_t cmd,
    output wups_pkg::cell_t           head
);

    wups_pkg::cell_t      cells [wups_pkg::DEPTH];
    logic                 takes [wups_pkg::DEPTH];

    localparam wups_pkg::cell_t EMPTY_CELL = '0;

    assign head = cells[0];

    genvar i;
    generate
        for (i = 0; i < wups_pkg::DEPTH; i++)
        begin : g_cell
            logic                 take_left;
            wups_pkg::cell_t      left;
            wups_pkg::cell_t      right;
            wups_pkg::chain_cmd_t cell_cmd;

            // Only the head decrements; the rest hold
            always_comb
            begin
                cell_cmd = cmd;
                if ((i != 0) && (cmd.cmd == wups_pkg::CMD_DEC))
                    cell_cmd.cmd = wups_pkg::CMD_HOLD;
            end

            if (i == 0)
            begin : g_first
                assign take_left = 1'b0;
                assign left      = EMPTY_CELL;
            end
            else
            begin : g_inner
                assign take_left = takes[i-1];
                assign left      = cells[i-1];
            end

            if (i == wups_pkg::DEPTH - 1)
            begin : g_last
                assign right = EMPTY_CELL;
            end
            else
            begin : g_mid
                assign right = cells[i+1];
            end

            wups_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cell_cmd),
                .take_left (take_left),
                .left      (left),
                .right     (right),
                .take      (takes[i]),
                .state     (cells[i])
            );

            // Chain stays a sorted prefix of valid slots
            if (i < wups_pkg::DEPTH - 1)
            begin : g_chk
                `WUPS_ASSERT_IMP(a_prefix, !cells[i].valid, !cells[i+1].valid,
                    "valid slot after an empty one")
                `WUPS_ASSERT_IMP(a_sorted, cells[i+1].valid,
                    cells[i].weight >= cells[i+1].weight, "chain out of weight order")
            end
        end
    endgenerate

    `WUPS_ASSERT_IMP(a_pop_head, cmd.cmd == wups_pkg::CMD_POP || cmd.cmd == wups_pkg::CMD_DEC,
        cells[0].valid, "serve issued on empty chain")

endmodule
`default_nettype wire

/* hdl/weighted_unit_priority_scheduler.sv */
// A beat fills the op, weight, units and product registers (the multiply is registered
// ahead of the chain update); no new item is taken until the execute step has run.
// Every arrive, tick or clear completes in one step of the sorted cell chain.
// Output holds in a register, so a stalled result delays only the execute step.
// Reset (rst_n low, async): chain empty, total and job count zero, no result pending.
// Top level of the weighted unit priority scheduler.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_unit_priority_scheduler_assert.svh"
module weighted_unit_priority_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    input  wire logic [31:0] s_tdata,   // job_weight[15:0], job_units[31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata    // penalty_total[47:0], served_weight[63:48],
                                        // served[64], insert_rejected[65], job_count[72:66], zero
);

    logic                               busy_reg;
    logic [1:0]                         op_reg;
    logic [wups_pkg::WEIGHT_BITS-1:0]   w_reg;
    logic [wups_pkg::UNITS_BITS-1:0]    u_reg;
    logic [wups_pkg::PROD_BITS-1:0]     prod_reg;
    logic [wups_pkg::SUM_BITS-1:0]      sum_reg, sum_next;
    logic [wups_pkg::COUNT_BITS-1:0]    count_reg, count_next;

    logic                               out_valid_reg;
    logic [wups_pkg::SUM_BITS-1:0]      out_sum_reg;
    logic [wups_pkg::FIELD_BITS-1:0]    out_sw_reg, sw_next;
    logic                               out_served_reg, served_next;
    logic                               out_rej_reg, rej_next;
    logic [wups_pkg::CNT_OUT_BITS-1:0]  out_cnt_reg;

    logic                               in_beat;
    logic                               exec;
    wups_pkg::chain_cmd_t               cmd;
    wups_pkg::cell_t                    head;

    assign s_tready = !busy_reg;
    assign in_beat  = s_tvalid && s_tready;
    assign exec     = busy_reg && (!out_valid_reg || m_tready);

    // Capture the item and its weight-times-units product
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg   <= s_tuser;
            w_reg    <= wups_pkg::fit_weight(s_tdata[15:0]);
            u_reg    <= wups_pkg::fit_units(s_tdata[31:16]);
            prod_reg <= wups_pkg::fit_weight(s_tdata[15:0]) * wups_pkg::fit_units(s_tdata[31:16]);
        end
    end

    // Execute: decide chain command and new totals
    always_comb
    begin
        cmd.cmd     = wups_pkg::CMD_HOLD;
        cmd.weight  = w_reg;
        cmd.units   = u_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        sw_next     = '0;
        served_next = 1'b0;
        rej_next    = 1'b0;
        case (op_reg)
            wups_pkg::OP_ARRIVE:
            begin
                if (u_reg != '0)
                begin
                    if (count_reg == wups_pkg::COUNT_BITS'(wups_pkg::DEPTH))
                        rej_next = 1'b1;
                    else
                    begin
                        cmd.cmd    = wups_pkg::CMD_INSERT;
                        sum_next   = sum_reg + wups_pkg::fit_sum(prod_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            wups_pkg::OP_TICK:
            begin
                if (head.valid)
                begin
                    served_next = 1'b1;
                    sw_next     = wups_pkg::weight_field(head.weight);
                    sum_next    = sum_reg - wups_pkg::fit_sum(
                                      {{wups_pkg::UNITS_BITS{1'b0}}, head.weight});
                    if (head.units == wups_pkg::UNITS_BITS'(1))
                    begin
                        cmd.cmd    = wups_pkg::CMD_POP;
                        count_next = count_reg - 1'b1;
                    end
                    else
                        cmd.cmd = wups_pkg::CMD_DEC;
                end
            end
            wups_pkg::OP_CLEAR:
            begin
                cmd.cmd    = wups_pkg::CMD_CLEAR;
                sum_next   = '0;
                count_next = '0;
            end
            default:
            begin
                cmd.cmd = wups_pkg::CMD_HOLD;
            end
        endcase
        if (!exec)
            cmd.cmd = wups_pkg::CMD_HOLD;
    end

    wups_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head)
    );

    // Control and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_beat)
                busy_reg <= 1'b1;
            else if (exec)
                busy_reg <= 1'b0;

            if (exec)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= sum_next;
                count_reg     <= count_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_sum_reg    <= sum_next;
            out_sw_reg     <= sw_next;
            out_served_reg <= served_next;
            out_rej_reg    <= rej_next;
            out_cnt_reg    <= wups_pkg::count_field(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_cnt_reg, out_rej_reg, out_served_reg, out_sw_reg, out_sum_reg};

    `WUPS_ASSERT_IMP(a_head_count, 1'b1, head.valid == (count_reg != '0),
        "chain head disagrees with job count")
    `WUPS_ASSERT_IMP(a_count_max, 1'b1, count_reg <= wups_pkg::COUNT_BITS'(wups_pkg::DEPTH),
        "job count above depth")
    `WUPS_ASSERT_IMP(a_result_src, $rose(out_valid_reg), $past(busy_reg),
        "result without an item in work")
    `WUPS_ASSERT_IMP(a_served_w, out_valid_reg && !out_served_reg, out_sw_reg == '0,
        "served weight set without a serve")

endmodule
`default_nettype wire

/* tb/sv/tb_weighted_unit_priority_scheduler.sv */
// Self-checking testbench for the weighted unit priority scheduler.
`timescale 1ns / 1ps
module tb_weighted_unit_priority_scheduler;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 560;
    localparam int IDLE_PCT     = 38;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Opcode value the block has no use for
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One result beat, unpacked
    typedef struct packed {
        logic [wups_pkg::SUM_BITS-1:0]     total;
        logic [wups_pkg::FIELD_BITS-1:0]   served_weight;
        logic                              served;
        logic                              rejected;
        logic [wups_pkg::CNT_OUT_BITS-1:0] jobs;
    } sched_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = '0;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    // Predicted scheduler state
    logic [wups_pkg::FIELD_BITS-1:0] sched_weight [wups_pkg::DEPTH];
    logic [wups_pkg::FIELD_BITS-1:0] sched_units  [wups_pkg::DEPTH];
    logic                            sched_valid  [wups_pkg::DEPTH];
    logic [wups_pkg::SUM_BITS-1:0]   sched_total;
    int                              sched_jobs;

    sched_result_t pending_results[$];

    bit calm = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int arrive_count = 0;
    int reject_count = 0;
    int tick_count = 0;
    int served_count = 0;
    int clear_count = 0;
    int peak_jobs = 0;

    weighted_unit_priority_scheduler u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),   // opcode[1:0]
        .s_tdata  (s_tdata),   // job_weight[15:0], job_units[31:16]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // penalty_total[47:0], served_weight[63:48],
                               // served[64], insert_rejected[65], job_count[72:66], zero
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Apply one item to the predicted state, return the result it causes
    function automatic sched_result_t schedule_step(input logic [1:0] op,
                                                    input logic [wups_pkg::FIELD_BITS-1:0] w,
                                                    input logic [wups_pkg::FIELD_BITS-1:0] u);
        sched_result_t r;
        int free_slot;
        int best;
        r = '0;
        free_slot = -1;
        best = -1;
        case (op)
            wups_pkg::OP_ARRIVE:
            begin
                arrive_count++;
                if (u != '0)
                begin
                    for (int k = 0; k < wups_pkg::DEPTH; k++)
                        if (!sched_valid[k] && free_slot < 0)
                            free_slot = k;
                    if (free_slot < 0)
                    begin
                        r.rejected = 1'b1;
                        reject_count++;
                    end
                    else
                    begin
                        sched_valid[free_slot]  = 1'b1;
                        sched_weight[free_slot] = w;
                        sched_units[free_slot]  = u;
                        sched_total = sched_total +
                                      wups_pkg::SUM_BITS'(w) * wups_pkg::SUM_BITS'(u);
                        sched_jobs++;
                    end
                end
            end
            wups_pkg::OP_TICK:
            begin
                tick_count++;
                // greatest weight, lowest index on ties
                for (int k = 0; k < wups_pkg::DEPTH; k++)
                    if (sched_valid[k] && (best < 0 || sched_weight[k] > sched_weight[best]))
                        best = k;
                if (best >= 0)
                begin
                    served_count++;
                    r.served = 1'b1;
                    r.served_weight = sched_weight[best];
                    sched_total = sched_total - wups_pkg::SUM_BITS'(sched_weight[best]);
                    sched_units[best] = sched_units[best] - 1'b1;
                    if (sched_units[best] == '0)
                    begin
                        sched_valid[best] = 1'b0;
                        sched_jobs--;
                    end
                end
            end
            wups_pkg::OP_CLEAR:
            begin
                clear_count++;
                for (int k = 0; k < wups_pkg::DEPTH; k++)
                    sched_valid[k] = 1'b0;
                sched_total = '0;
                sched_jobs = 0;
            end
            default: ;
        endcase
        if (sched_jobs > peak_jobs)
            peak_jobs = sched_jobs;
        r.total = sched_total;
        r.jobs = wups_pkg::CNT_OUT_BITS'(sched_jobs);
        return r;
    endfunction

    // Send one item beat, with random gaps ahead of it
    task automatic send_item(input logic [1:0] op,
                             input logic [wups_pkg::FIELD_BITS-1:0] w,
                             input logic [wups_pkg::FIELD_BITS-1:0] u);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {u, w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), schedule_step(op, w, u));
        items_sent++;
    endtask

    // Receiver: random stalls, compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        sched_result_t want;
        sched_result_t got;
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.total         = m_tdata[47:0];
            got.served_weight = m_tdata[63:48];
            got.served        = m_tdata[64];
            got.rejected      = m_tdata[65];
            got.jobs          = m_tdata[72:66];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("[%0t] unexpected result beat: total=%0h jobs=%0d",
                             $realtime, got.total, got.jobs);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.total !== want.total || got.served_weight !== want.served_weight ||
                    got.served !== want.served || got.rejected !== want.rejected ||
                    got.jobs !== want.jobs)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("[%0t] result %0d mismatch", $realtime, results_seen);
                        $display("  expected total=%0h served_weight=%0h served=%0b rej=%0b jobs=%0d",
                                 want.total, want.served_weight, want.served, want.rejected,
                                 want.jobs);
                        $display("  actual   total=%0h served_weight=%0h served=%0b rej=%0b jobs=%0d",
                                 got.total, got.served_weight, got.served, got.rejected,
                                 got.jobs);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Field extremes, ties, zero weight and zero units, empty tick, unused opcode, clear
    task automatic test_directed_cases();
        send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_UNUSED, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_ARRIVE, 16'hFFFF, 16'hFFFF);
        send_item(wups_pkg::OP_ARRIVE, 16'h0000, 16'hFFFF);
        send_item(wups_pkg::OP_ARRIVE, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_ARRIVE, 16'hFFFF, 16'h0000);
        send_item(wups_pkg::OP_ARRIVE, 16'hFFFF, 16'h0001);
        send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        send_item(wups_pkg::OP_CLEAR, 16'hAAAA, 16'h5555);
        send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_ARRIVE, 16'd5, 16'd2);
        send_item(wups_pkg::OP_ARRIVE, 16'd9, 16'd1);
        send_item(wups_pkg::OP_ARRIVE, 16'd5, 16'd1);
        repeat (5)
            send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_ARRIVE, 16'hAAAA, 16'h5555);
        send_item(wups_pkg::OP_ARRIVE, 16'h5555, 16'hAAAA);
        send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    endtask

    // Fill every slot, overflow it, free a slot and reuse it, clear a full table
    task automatic test_full_table();
        send_item(wups_pkg::OP_CLEAR, 16'h0000, 16'h0000);
        repeat (wups_pkg::DEPTH)
            send_item(wups_pkg::OP_ARRIVE, 16'($urandom), 16'($urandom_range(1, 3)));
        send_item(wups_pkg::OP_ARRIVE, 16'($urandom), 16'($urandom_range(1, 3)));
        send_item(wups_pkg::OP_ARRIVE, 16'hFFFF, 16'hFFFF);
        repeat (4)
            send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_ARRIVE, 16'($urandom), 16'd2);
        send_item(wups_pkg::OP_ARRIVE, 16'($urandom), 16'd2);
        while (sched_jobs < wups_pkg::DEPTH)
            send_item(wups_pkg::OP_ARRIVE, 16'($urandom_range(0, 7)), 16'd1);
        send_item(wups_pkg::OP_ARRIVE, 16'd1, 16'd1);
        send_item(wups_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    endtask

    // Mostly arrive and tick traffic, alternating arrive-heavy and tick-heavy stretches
    task automatic test_random_traffic();
        int pick;
        int arrive_pct;
        logic [wups_pkg::FIELD_BITS-1:0] w;
        logic [wups_pkg::FIELD_BITS-1:0] u;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 200 && n < 320);
            arrive_pct = ((n / 100) % 2 == 0) ? 65 : 35;
            pick = $urandom_range(0, 999);
            w = ($urandom_range(0, 9) < 4) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            case ($urandom_range(0, 49))
                0:       u = 16'h0000;
                1:       u = 16'($urandom);
                2, 3, 4,
                5, 6, 7: u = 16'($urandom_range(1, 300));
                default: u = 16'($urandom_range(1, 4));
            endcase
            if (pick < 6)
                send_item(wups_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
            else if (pick < 26)
                send_item(OP_UNUSED, 16'($urandom), 16'($urandom));
            else if (pick < 26 + arrive_pct * 10)
                send_item(wups_pkg::OP_ARRIVE, w, u);
            else
                send_item(wups_pkg::OP_TICK, 16'($urandom), 16'($urandom));
        end
        calm = 1'b0;
    endtask

    // Serve a small table down to empty, then tick once more
    task automatic test_drain_to_empty();
        send_item(wups_pkg::OP_CLEAR, 16'h0000, 16'h0000);
        repeat (4)
            send_item(wups_pkg::OP_ARRIVE, 16'($urandom_range(0, 3)), 16'($urandom_range(1, 3)));
        while (sched_jobs != 0)
            send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(wups_pkg::OP_TICK, 16'h0000, 16'h0000);
    endtask

    // Test sequence
    initial
    begin
        for (int k = 0; k < wups_pkg::DEPTH; k++)
        begin
            sched_valid[k]  = 1'b0;
            sched_weight[k] = '0;
            sched_units[k]  = '0;
        end
        sched_total = '0;
        sched_jobs = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_table();
        test_random_traffic();
        test_drain_to_empty();
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d items: %0d arrives (%0d rejected), %0d ticks (%0d served), %0d clears",
                 items_sent, arrive_count, reject_count, tick_count, served_count, clear_count);
        $display("peak occupancy %0d of %0d slots, %0d result beats, %0d mismatches",
                 peak_jobs, wups_pkg::DEPTH, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
